// ===== rtl/ert_pkg.sv =====
`default_nettype none

package ert_pkg;

    // Command codes carried by a request.
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_FETCH    = 2'd1;
    localparam logic [1:0] CMD_ACK      = 2'd2;

    // Report levels of a register request.
    localparam logic [1:0] LVL_ONCE     = 2'd0;
    localparam logic [1:0] LVL_ACKED    = 2'd1;

    // Status codes of a result.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_BAD_LEVEL = 2'd2;

    // Table selectors.
    localparam logic TBL_ONCE  = 1'b0;
    localparam logic TBL_ACKED = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Operation being worked on by the sequencer.
    typedef enum logic [1:0] {
        OP_REG_ONCE,
        OP_REG_ACKED,
        OP_FETCH,
        OP_ACK
    } op_t;

    // One request as it arrives.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  code;
        logic [31:0] time_stamp;
        logic [31:0] min_gap;
        logic [1:0]  level;
    } request_t;

    // One result as it leaves.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_code;
        logic [31:0] out_time;
        logic        out_table;
    } result_t;

    // One stored table entry.
    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] entry_time;
        logic [31:0] gap;
        logic [31:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/ert_ram.sv =====
`default_nettype none

module ert_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/error_report_table_unit.sv =====
`default_nettype none

// Channel   Ports                  Handshake
// request   start, busy, request   taken at a rising edge with start high and busy low
// result    done, result           done is high for one cycle; taken at the edge ending it
//
// The entries sit in one RAM that both tables share; the sequencer reads one entry per
// cycle and checks it in a single subtract-and-compare unit, so the scan length sets how
// long a request takes. A fetch that finds nothing scans both tables in full.
// Reset clears the tick, the valid bits, the round-robin slot and the pending mark at once.
// busy stays high from acceptance through the done cycle; the receiver cannot stall.

module error_report_table_unit #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire ert_pkg::request_t request,
    output      logic              done,
    output      ert_pkg::result_t  result
);

    import ert_pkg::*;

    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOTS    = 1 << IDX_W;
    localparam int ADDR_W   = IDX_W + 1;
    localparam int RAM_SIZE = 2 * SLOTS;
    localparam int ENTRY_W  = $bits(entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    request_t           req_reg;
    logic               tbl_reg, tbl_next;
    logic [IDX_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               issue_on_reg, issue_on_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_on_reg, chk_on_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [31:0]        tick_reg, tick_next;
    logic [IDX_W-1:0]   next_slot_reg, next_slot_next;
    logic [SLOTS-1:0]   once_valid_reg, once_valid_next;
    logic [SLOTS-1:0]   ack_valid_reg, ack_valid_next;
    logic               pending_valid_reg, pending_valid_next;
    logic [IDX_W-1:0]   pending_slot_reg, pending_slot_next;
    result_t            result_reg, result_next;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_entry;

    logic               accept;
    op_t                dec_op;
    logic               dec_imm;
    logic [1:0]         dec_status;

    entry_t             ent;
    logic [31:0]        elapsed;
    logic               overdue;
    logic               code_eq;
    logic               stamp_zero;
    logic               entry_valid;
    logic               hit;
    logic               chk_last;
    logic               issue_last;
    logic               conclude;
    logic               free_any;
    logic [IDX_W-1:0]   free_sel;

    assign accept = start && (state_reg == S_IDLE);

    // Entry store for both tables: the table bit selects the upper half.
    ert_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Decode the incoming request into an operation or an immediate answer.
    always_comb
    begin
        dec_op     = OP_FETCH;
        dec_imm    = 1'b0;
        dec_status = STS_OK;
        case (request.cmd)
            CMD_REGISTER:
            begin
                if (request.level == LVL_ONCE)
                begin
                    dec_op = OP_REG_ONCE;
                end
                else if (request.level == LVL_ACKED)
                begin
                    dec_op = OP_REG_ACKED;
                end
                else
                begin
                    dec_imm    = 1'b1;
                    dec_status = STS_BAD_LEVEL;
                end
            end
            CMD_FETCH:
            begin
                dec_op = OP_FETCH;
            end
            CMD_ACK:
            begin
                if (pending_valid_reg)
                begin
                    dec_op = OP_ACK;
                end
                else
                begin
                    dec_imm    = 1'b1;
                    dec_status = STS_EMPTY;
                end
            end
            default:
            begin
                dec_imm    = 1'b1;
                dec_status = STS_EMPTY;
            end
        endcase
    end

    // Shared check unit: elapsed-time compare and code match on the entry just read.
    assign ent         = entry_t'(rd_data);
    assign elapsed     = tick_reg - ent.stamp;
    assign overdue     = elapsed > ent.gap;
    assign code_eq     = ent.code == req_reg.code;
    assign stamp_zero  = ent.stamp == 32'd0;
    assign entry_valid = (tbl_reg == TBL_ACKED) ? ack_valid_reg[chk_idx_reg]
                                                : once_valid_reg[chk_idx_reg];

    always_comb
    begin
        case (op_reg)
            OP_REG_ONCE:  hit = entry_valid && code_eq;
            OP_REG_ACKED: hit = entry_valid && code_eq;
            OP_FETCH:
            begin
                if (tbl_reg == TBL_ONCE)
                begin
                    hit = entry_valid && stamp_zero;
                end
                else
                begin
                    hit = entry_valid && (stamp_zero || overdue);
                end
            end
            OP_ACK:       hit = 1'b1;
            default:      hit = 1'b0;
        endcase
    end

    assign issue_last = (op_reg == OP_ACK) || (issue_idx_reg == LAST_IDX);
    assign chk_last   = (op_reg == OP_ACK) || (chk_idx_reg == LAST_IDX);
    assign conclude   = chk_on_reg &&
                        (hit || (chk_last && !(op_reg == OP_FETCH && tbl_reg == TBL_ONCE)));
    assign free_any   = free_found_reg || !entry_valid;
    assign free_sel   = free_found_reg ? free_idx_reg : chk_idx_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = dec_imm ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (conclude)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs, scan pointers and table updates.
    always_comb
    begin
        op_next            = op_reg;
        tbl_next           = tbl_reg;
        issue_idx_next     = issue_idx_reg;
        issue_on_next      = issue_on_reg;
        chk_idx_next       = chk_idx_reg;
        chk_on_next        = chk_on_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        tick_next          = tick_reg;
        next_slot_next     = next_slot_reg;
        once_valid_next    = once_valid_reg;
        ack_valid_next     = ack_valid_reg;
        pending_valid_next = pending_valid_reg;
        pending_slot_next  = pending_slot_reg;
        result_next        = result_reg;
        rd_en              = 1'b0;
        rd_addr            = {tbl_reg, issue_idx_reg};
        wr_en              = 1'b0;
        wr_addr            = {TBL_ONCE, chk_idx_reg};
        wr_entry           = ent;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = dec_op;
                    tbl_next        = (dec_op == OP_REG_ACKED || dec_op == OP_ACK) ?
                                      TBL_ACKED : TBL_ONCE;
                    issue_idx_next  = (dec_op == OP_ACK) ? pending_slot_reg : '0;
                    issue_on_next   = 1'b1;
                    chk_on_next     = 1'b0;
                    free_found_next = 1'b0;
                    result_next     = '{status: dec_status, out_code: 8'd0,
                                        out_time: 32'd0, out_table: TBL_ONCE};
                    if (request.cmd == CMD_FETCH)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                end
            end
            S_SCAN:
            begin
                // Read ahead one entry while checking the previous one.
                rd_en          = issue_on_reg;
                chk_on_next    = issue_on_reg;
                chk_idx_next   = issue_idx_reg;
                issue_idx_next = issue_idx_reg + 1'b1;
                issue_on_next  = issue_on_reg && !issue_last;

                if (chk_on_reg)
                begin
                    result_next = '{status: STS_OK, out_code: 8'd0,
                                    out_time: 32'd0, out_table: TBL_ONCE};
                    if (hit)
                    begin
                        case (op_reg)
                            OP_REG_ONCE:
                            begin
                                // Re-arm a known code only once its gap has run out.
                                wr_en    = overdue;
                                wr_addr  = {TBL_ONCE, chk_idx_reg};
                                wr_entry = '{code: ent.code, entry_time: req_reg.time_stamp,
                                             gap: ent.gap, stamp: 32'd0};
                            end
                            OP_FETCH:
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = {tbl_reg, chk_idx_reg};
                                wr_entry    = '{code: ent.code, entry_time: ent.entry_time,
                                                gap: ent.gap, stamp: tick_reg};
                                result_next = '{status: STS_OK, out_code: ent.code,
                                                out_time: ent.entry_time, out_table: tbl_reg};
                                if (tbl_reg == TBL_ONCE)
                                begin
                                    pending_valid_next = 1'b0;
                                end
                                else
                                begin
                                    pending_valid_next = 1'b1;
                                    pending_slot_next  = chk_idx_reg;
                                end
                            end
                            OP_ACK:
                            begin
                                result_next = '{status: STS_OK, out_code: ent.code,
                                                out_time: ent.entry_time,
                                                out_table: TBL_ACKED};
                                ack_valid_next[chk_idx_reg] = 1'b0;
                                pending_valid_next          = 1'b0;
                            end
                            default:
                            begin
                                // A duplicate acknowledged code changes nothing.
                            end
                        endcase
                    end
                    else if (chk_last)
                    begin
                        case (op_reg)
                            OP_REG_ONCE:
                            begin
                                // New code goes to the round-robin slot.
                                wr_en    = 1'b1;
                                wr_addr  = {TBL_ONCE, next_slot_reg};
                                wr_entry = '{code: req_reg.code,
                                             entry_time: req_reg.time_stamp,
                                             gap: req_reg.min_gap, stamp: 32'd0};
                                once_valid_next[next_slot_reg] = 1'b1;
                                next_slot_next = (next_slot_reg == LAST_IDX) ?
                                                 '0 : next_slot_reg + 1'b1;
                            end
                            OP_REG_ACKED:
                            begin
                                // New code goes to the first free slot; a full table drops it.
                                wr_en    = free_any;
                                wr_addr  = {TBL_ACKED, free_sel};
                                wr_entry = '{code: req_reg.code,
                                             entry_time: req_reg.time_stamp,
                                             gap: req_reg.min_gap, stamp: 32'd0};
                                if (free_any)
                                begin
                                    ack_valid_next[free_sel] = 1'b1;
                                end
                            end
                            OP_FETCH:
                            begin
                                if (tbl_reg == TBL_ONCE)
                                begin
                                    // Nothing unsent in the report-once table: try the other.
                                    tbl_next       = TBL_ACKED;
                                    issue_idx_next = '0;
                                    issue_on_next  = 1'b1;
                                    chk_on_next    = 1'b0;
                                end
                                else
                                begin
                                    result_next.status = STS_EMPTY;
                                end
                            end
                            default:
                            begin
                                result_next.status = STS_EMPTY;
                            end
                        endcase
                    end
                    else if (!free_found_reg && !entry_valid)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        busy   = state_reg != S_IDLE;
        done   = state_reg == S_DONE;
        result = result_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_FETCH;
            tbl_reg           <= TBL_ONCE;
            issue_on_reg      <= 1'b0;
            chk_on_reg        <= 1'b0;
            free_found_reg    <= 1'b0;
            tick_reg          <= 32'd0;
            next_slot_reg     <= '0;
            once_valid_reg    <= '0;
            ack_valid_reg     <= '0;
            pending_valid_reg <= 1'b0;
            pending_slot_reg  <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            op_reg            <= op_next;
            tbl_reg           <= tbl_next;
            issue_on_reg      <= issue_on_next;
            chk_on_reg        <= chk_on_next;
            free_found_reg    <= free_found_next;
            tick_reg          <= tick_next;
            next_slot_reg     <= next_slot_next;
            once_valid_reg    <= once_valid_next;
            ack_valid_reg     <= ack_valid_next;
            pending_valid_reg <= pending_valid_next;
            pending_slot_reg  <= pending_slot_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        issue_idx_reg <= issue_idx_next;
        chk_idx_reg   <= chk_idx_next;
        free_idx_reg  <= free_idx_next;
        result_reg    <= result_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    // Each result is strobed for a single cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held for more than one cycle");

    // The pending mark always points at a live acknowledged entry.
    a_pending_live: assert property (@(posedge clk) disable iff (!rst_n)
        pending_valid_reg |-> ack_valid_reg[pending_slot_reg])
        else $error("pending entry is not valid");

    // The round-robin slot stays inside the table.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot_reg <= LAST_IDX)
        else $error("round-robin slot out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/error_report_table_unit_test.sv =====
`default_nettype none

module error_report_table_unit_test;

    import ert_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_REQUESTS = 500;
    localparam int DRAIN_EVERY = 120;
    // Longest request: a fetch that scans both tables, plus the done cycle.
    localparam int MAX_LATENCY = 2 * TABLE_DEPTH + 3;
    localparam int CYCLE_LIMIT = 400000;

    // Command value with no operation behind it, and the two rejected levels.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [1:0] LVL_BAD_LOW  = 2'd2;
    localparam logic [1:0] LVL_BAD_HIGH = 2'd3;

    // Predicts the answer of every accepted request and checks the results in order.
    class report_table_predictor;
        bit [31:0]   tick;
        int unsigned rr_slot;
        bit          once_live [TABLE_DEPTH];
        bit [7:0]    once_num  [TABLE_DEPTH];
        bit [31:0]   once_when [TABLE_DEPTH];
        bit [31:0]   once_gap  [TABLE_DEPTH];
        bit [31:0]   once_sent [TABLE_DEPTH];
        bit          ack_live  [TABLE_DEPTH];
        bit [7:0]    ack_num   [TABLE_DEPTH];
        bit [31:0]   ack_when  [TABLE_DEPTH];
        bit [31:0]   ack_gap   [TABLE_DEPTH];
        bit [31:0]   ack_sent  [TABLE_DEPTH];
        bit          awaiting_ack;
        int unsigned awaiting_slot;
        result_t     expected_results [$];
        int unsigned mismatches;
        int unsigned once_sends;
        int unsigned acked_sends;
        int unsigned acks_cleared;
        int unsigned idle_answers;
        int unsigned rejected;

        // Applies a register request to the tables and returns its status.
        function logic [1:0] register_error(request_t req);
            if (req.level == LVL_ONCE)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (once_live[i] && once_num[i] == req.code)
                    begin
                        // Re-arm only when more than the stored gap has passed.
                        if (tick - once_sent[i] > once_gap[i])
                        begin
                            once_sent[i] = '0;
                            once_when[i] = req.time_stamp;
                        end
                        return STS_OK;
                    end
                end
                once_live[rr_slot] = 1'b1;
                once_num[rr_slot]  = req.code;
                once_when[rr_slot] = req.time_stamp;
                once_gap[rr_slot]  = req.min_gap;
                once_sent[rr_slot] = '0;
                rr_slot = (rr_slot + 1) % TABLE_DEPTH;
                return STS_OK;
            end
            if (req.level == LVL_ACKED)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (ack_live[i] && ack_num[i] == req.code)
                        return STS_OK;
                end
                // A full table drops the new code silently.
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!ack_live[i])
                    begin
                        ack_live[i] = 1'b1;
                        ack_num[i]  = req.code;
                        ack_when[i] = req.time_stamp;
                        ack_gap[i]  = req.min_gap;
                        ack_sent[i] = '0;
                        return STS_OK;
                    end
                end
                return STS_OK;
            end
            rejected++;
            return STS_BAD_LEVEL;
        endfunction

        // Advances the tick and picks the next report to send.
        function result_t fetch_report();
            result_t r;
            r = '0;
            tick = tick + 32'd1;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (once_live[i] && once_sent[i] == 32'd0)
                begin
                    once_sent[i] = tick;
                    awaiting_ack = 1'b0;
                    r.status    = STS_OK;
                    r.out_code  = once_num[i];
                    r.out_time  = once_when[i];
                    r.out_table = TBL_ONCE;
                    once_sends++;
                    return r;
                end
            end
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (ack_live[i] && (ack_sent[i] == 32'd0 || tick - ack_sent[i] > ack_gap[i]))
                begin
                    ack_sent[i]   = tick;
                    awaiting_ack  = 1'b1;
                    awaiting_slot = i;
                    r.status    = STS_OK;
                    r.out_code  = ack_num[i];
                    r.out_time  = ack_when[i];
                    r.out_table = TBL_ACKED;
                    acked_sends++;
                    return r;
                end
            end
            r.status = STS_EMPTY;
            idle_answers++;
            return r;
        endfunction

        // Notes an accepted request and queues the result it must produce.
        function void note_request(request_t req);
            result_t r;
            r = '0;
            if (req.cmd == CMD_REGISTER)
            begin
                r.status = register_error(req);
            end
            else if (req.cmd == CMD_FETCH)
            begin
                r = fetch_report();
            end
            else if (req.cmd == CMD_ACK && awaiting_ack)
            begin
                r.status    = STS_OK;
                r.out_code  = ack_num[awaiting_slot];
                r.out_time  = ack_when[awaiting_slot];
                r.out_table = TBL_ACKED;
                ack_live[awaiting_slot] = 1'b0;
                awaiting_ack = 1'b0;
                acks_cleared++;
            end
            else
            begin
                r.status = STS_EMPTY;
                idle_answers++;
            end
            expected_results.push_back(r);
        endfunction

        // Prints one line for a mismatch and counts it.
        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
        endtask

        // Compares one result with the oldest outstanding prediction.
        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding", 32'(got.status), '0);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.out_code !== want.out_code)
                report_mismatch("out_code", 32'(got.out_code), 32'(want.out_code));
            if (got.out_time !== want.out_time)
                report_mismatch("out_time", got.out_time, want.out_time);
            if (got.out_table !== want.out_table)
                report_mismatch("out_table", 32'(got.out_table), 32'(want.out_table));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    report_table_predictor board;
    int unsigned cycle_count;
    int unsigned issued;

    error_report_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    // Free-running clock.
    always #CLK_HALF clk = ~clk;

    // Run-time watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("error_report_table_unit_test: FAIL");
            $finish;
        end
    end

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    // Idle time before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Builds a request; codes mostly come from a small pool so that entries repeat.
    function automatic request_t make_request(logic [1:0] cmd, logic [1:0] level);
        request_t r;
        r.cmd   = cmd;
        r.level = level;
        if ($urandom_range(99) < 75)
            r.code = 8'h30 + 8'($urandom_range(0, 11));
        else
            r.code = 8'($urandom_range(0, 255));
        r.time_stamp = $urandom();
        if ($urandom_range(99) < 80)
            r.min_gap = $urandom_range(0, 6);
        else
            r.min_gap = $urandom();
        return r;
    endfunction

    function automatic request_t random_request();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return make_request(CMD_REGISTER, LVL_ONCE);
        if (roll < 45)
            return make_request(CMD_REGISTER, LVL_ACKED);
        if (roll < 78)
            return make_request(CMD_FETCH, 2'($urandom_range(0, 3)));
        if (roll < 92)
            return make_request(CMD_ACK, 2'($urandom_range(0, 3)));
        if (roll < 96)
            return make_request(CMD_REGISTER, 2'($urandom_range(2, 3)));
        return make_request(CMD_UNUSED, 2'($urandom_range(0, 3)));
    endfunction

    function automatic request_t fixed_request(logic [1:0] cmd, logic [7:0] code,
                                               logic [31:0] stamp, logic [31:0] gap,
                                               logic [1:0] level);
        request_t r;
        r.cmd        = cmd;
        r.code       = code;
        r.time_stamp = stamp;
        r.min_gap    = gap;
        r.level      = level;
        return r;
    endfunction

    // Presents one request after a random pause and waits until busy falls again.
    task automatic issue_request(request_t req);
        int idle;
        idle = pick_gap();
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        request <= req;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(req);
        issued++;
    endtask

    // Holds requests back until every outstanding result has arrived.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (board.expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board       = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cycle_count = 0;
        issued      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty tables, unused command and rejected levels first.
        issue_request(fixed_request(CMD_FETCH, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        issue_request(fixed_request(CMD_ACK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    LVL_BAD_HIGH));
        issue_request(fixed_request(CMD_UNUSED, 8'h5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                    LVL_ACKED));
        issue_request(fixed_request(CMD_REGISTER, 8'h11, 32'h1, 32'h1, LVL_BAD_LOW));
        issue_request(fixed_request(CMD_REGISTER, 8'hFF, 32'hFFFF_FFFF, 32'h0, LVL_BAD_HIGH));
        // Report-once entries at the field extremes, then sent.
        issue_request(fixed_request(CMD_REGISTER, 8'h00, 32'hFFFF_FFFF, 32'h0, LVL_ONCE));
        issue_request(fixed_request(CMD_REGISTER, 8'hFF, 32'h0, 32'hFFFF_FFFF, LVL_ONCE));
        issue_request(fixed_request(CMD_FETCH, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        issue_request(fixed_request(CMD_FETCH, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        // A zero gap has elapsed and re-arms; the largest gap never does.
        issue_request(fixed_request(CMD_REGISTER, 8'h00, 32'h1234_5678, 32'h9, LVL_ONCE));
        issue_request(fixed_request(CMD_REGISTER, 8'hFF, 32'h8765_4321, 32'h0, LVL_ONCE));
        issue_request(fixed_request(CMD_FETCH, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        // Acknowledged entry, its duplicate, a send, a clear and a clear with none pending.
        issue_request(fixed_request(CMD_REGISTER, 8'h07, 32'hCAFE_0001, 32'h0, LVL_ACKED));
        issue_request(fixed_request(CMD_REGISTER, 8'h07, 32'hCAFE_0002, 32'h3, LVL_ACKED));
        issue_request(fixed_request(CMD_FETCH, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        issue_request(fixed_request(CMD_ACK, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        issue_request(fixed_request(CMD_ACK, 8'h00, 32'h0, 32'h0, LVL_ONCE));
        // Overfill the acknowledged table so the last code is dropped.
        for (int i = 0; i <= TABLE_DEPTH; i++)
            issue_request(fixed_request(CMD_REGISTER, 8'h80 + 8'(i), 32'(i * 7), 32'(i),
                                        LVL_ACKED));
        wait_drained();

        // Random part, with fetch-then-clear pairs and periodic full drains.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(99) < 15)
            begin
                issue_request(make_request(CMD_FETCH, LVL_ONCE));
                issue_request(make_request(CMD_ACK, LVL_ONCE));
                n++;
            end
            else
            begin
                issue_request(random_request());
            end
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                wait_drained();
        end

        // Let the last results arrive and make sure nothing extra follows.
        wait_drained();
        repeat (MAX_LATENCY) @(posedge clk);

        $display("Ran %0d requests: %0d report-once sends, %0d acknowledged sends, %0d clears.",
                 issued, board.once_sends, board.acked_sends, board.acks_cleared);
        $display("Saw %0d empty or unused answers and %0d rejected levels; %0d mismatches.",
                 board.idle_answers, board.rejected, board.mismatches);
        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("error_report_table_unit_test: PASS");
        else
            $display("error_report_table_unit_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ert_pkg.sv
rtl/ert_ram.sv
rtl/error_report_table_unit.sv
tb/error_report_table_unit_test.sv
